// File: rtl/core/occupancy_block_free_check_macros.svh
// assertion macros shared by the checker of the occupancy block checker
// no dependencies; include by bare file name
`ifndef OCCUPANCY_BLOCK_FREE_CHECK_MACROS_SVH
`define OCCUPANCY_BLOCK_FREE_CHECK_MACROS_SVH

// antecedent in one cycle implies consequent in the next, quiet during reset
`define OCBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// same, but also checked while reset is applied
`define OCBF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ocbf_pkg.sv
// types and constants of the occupancy block checker
// no dependencies; imported by every module of the block but ocbf_ram
package ocbf_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int POS_W     = 11;
    localparam int BLK_W     = 10;
    localparam int COORD_W   = 10;
    localparam int CFG_IDX_W = 4;
    localparam int STEP_W    = 4;

    localparam int OUT_DATA_W = 24;
    localparam int OUT_PAD_W  = OUT_DATA_W - 2 * COORD_W - 1;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_W-1:0] BLOCK_LIMIT = 11'd1024;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FREE_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT     = 4'd3;

    // register reset values
    localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd240;
    localparam logic [CFG_W-1:0] BLOCK_RST     = 11'd8;
    localparam logic [CFG_W-1:0] WIDTH_RST     = 11'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RST    = 11'd1024;

    // one pixel of a complete block, as handed from front to back
    typedef struct packed {
        logic [POS_W-1:0]   idx;
        logic               first;
        logic               last_pix;
        logic               below;
        logic [COORD_W-1:0] crow;
        logic [COORD_W-1:0] ccol;
        logic               last_blk;
    } blk_op_t;

    // extent of the area covered by complete blocks
    typedef struct packed {
        logic             busy;
        logic [CFG_W-1:0] full_cols;
        logic [CFG_W-1:0] full_rows;
    } extent_t;

    typedef enum logic [1:0] {
        EXT_IDLE,
        EXT_COLS,
        EXT_ROWS
    } ext_state_t;

endpackage

// File: rtl/core/occupancy_block_free_check.sv
// top level of the occupancy block checker: front, queue and back
// uses ocbf_pkg, ocbf_front, ocbf_queue, ocbf_back
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid/s_tready    s_tdata: pixel
//  m_       out        m_tvalid/m_tready    m_tdata: center_row, center_col, accessible;
//                                           m_tlast: last_block
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one pixel per cycle while s_tready is high; a block result passes the queue, the
// flag stage and the result register; after reset the flag memory is cleared, one
// entry a cycle, all min(MAX_WIDTH, 2048) entries, with s_tready low; configuration
// writes are taken meanwhile; a write of block_size, map_width or map_height reruns
// the one-bit-a-cycle extent unit, which holds s_tready low until it is done
// a stalled result stops the back part at a last pixel; the queue holds 4 pixels
module occupancy_block_free_check import ocbf_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [9:0] center_row, [19:10] center_col,
                                             // [20] accessible, [23:21] zero
    output logic                  m_tlast
);

    // column index never exceeds the widest map the 11-bit register allows
    localparam int FLAG_DEPTH = (MAX_WIDTH > 2048) ? 2048 : MAX_WIDTH;

    logic    push, q_full, head_valid, pop, clr_busy;
    blk_op_t push_op, head_op;

    ocbf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .hold      (q_full || clr_busy),
        .push      (push),
        .push_op   (push_op)
    );

    ocbf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop)
    );

    ocbf_back #(
        .DEPTH (FLAG_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .clr_busy   (clr_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// File: rtl/core/ocbf_ram.sv
// generic single-port-write ram with registered read
// no dependencies
module ocbf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/ocbf_extent.sv
// works out the width and height covered by complete blocks
// restoring remainder unit, one bit a cycle; uses ocbf_pkg
module ocbf_extent import ocbf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [CFG_W-1:0] divisor,
    input  logic [CFG_W-1:0] width,
    input  logic [CFG_W-1:0] height,
    output extent_t          ext
);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CFG_W - 1);

    ext_state_t        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [CFG_W-1:0]  dvd_reg;
    logic [BLK_W-1:0]  rem_reg;
    logic [CFG_W-1:0]  fc_reg;
    logic [CFG_W-1:0]  fr_reg;

    logic [CFG_W-1:0]  rem_shift;
    logic [CFG_W-1:0]  rem_sub;
    logic [BLK_W-1:0]  rem_new;
    logic              last_step;

    assign rem_shift = {rem_reg, dvd_reg[CFG_W-1]};
    assign rem_sub   = rem_shift - divisor;
    // remainder stays below the divisor, which is at most 1024
    assign rem_new   = (rem_shift >= divisor) ? rem_sub[BLK_W-1:0] : rem_shift[BLK_W-1:0];
    assign last_step = (cnt_reg == STEP_LAST);

    always_comb begin
        state_next = state_reg;
        if (start) begin
            state_next = EXT_COLS;
        end else begin
            unique case (state_reg)
                EXT_IDLE: state_next = EXT_IDLE;
                EXT_COLS: state_next = last_step ? EXT_ROWS : EXT_COLS;
                EXT_ROWS: state_next = last_step ? EXT_IDLE : EXT_ROWS;
                default:  state_next = EXT_IDLE;
            endcase
        end
    end

    always_comb begin
        ext.busy      = start || (state_reg != EXT_IDLE);
        ext.full_cols = fc_reg;
        ext.full_rows = fr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EXT_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (start || last_step || state_reg == EXT_IDLE) begin
                cnt_reg <= '0;
            end else begin
                cnt_reg <= cnt_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= width;
            rem_reg <= '0;
        end else if (state_reg != EXT_IDLE) begin
            dvd_reg <= {dvd_reg[CFG_W-2:0], 1'b0};
            rem_reg <= rem_new;
            if (last_step && state_reg == EXT_COLS) begin
                fc_reg  <= width - {1'b0, rem_new};
                dvd_reg <= height;
                rem_reg <= '0;
            end
            if (last_step && state_reg == EXT_ROWS) begin
                fr_reg <= height - {1'b0, rem_new};
            end
        end
    end

endmodule

// File: rtl/core/ocbf_front.sv
// front part: configuration registers, scan position and pixel classification
// uses ocbf_pkg and ocbf_extent
module ocbf_front import ocbf_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,
    input  logic                 hold,
    output logic                 push,
    output blk_op_t              push_op
);

    localparam logic [CFG_W-1:0] W_LIMIT =
        (MAX_WIDTH > 2047) ? {CFG_W{1'b1}} : CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] H_LIMIT =
        (MAX_HEIGHT > 2047) ? {CFG_W{1'b1}} : CFG_W'(MAX_HEIGHT);

    logic [PIX_W-1:0] thr_reg;
    logic [CFG_W-1:0] bsz_reg, wid_reg, hgt_reg;
    logic             start_reg;

    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [BLK_W-1:0] cib_reg, cib_next;
    logic [BLK_W-1:0] rib_reg, rib_next;
    logic [POS_W-1:0] idx_reg, idx_next;

    logic [CFG_W-1:0] b, w, h, bm1;
    extent_t          ext;
    logic             accept;

    logic [POS_W-1:0] c0, r0, idx0;
    logic [BLK_W-1:0] cib0, rib0, cib1, rib1;
    logic [CFG_W-1:0] cib_inc, rib_inc;
    logic [POS_W-1:0] c_inc, r_inc;
    logic             in_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= THRESHOLD_RST;
            bsz_reg   <= BLOCK_RST;
            wid_reg   <= WIDTH_RST;
            hgt_reg   <= HEIGHT_RST;
            start_reg <= 1'b1;
        end else begin
            start_reg <= 1'b0;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_FREE_THRESHOLD: thr_reg <= cfg_data[PIX_W-1:0];
                    REG_BLOCK_SIZE: begin
                        bsz_reg   <= cfg_data;
                        start_reg <= 1'b1;
                    end
                    REG_MAP_WIDTH: begin
                        wid_reg   <= cfg_data;
                        start_reg <= 1'b1;
                    end
                    REG_MAP_HEIGHT: begin
                        hgt_reg   <= cfg_data;
                        start_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // zero acts as one, large values saturate
    always_comb begin
        b = (bsz_reg == '0) ? CFG_W'(1) : ((bsz_reg > BLOCK_LIMIT) ? BLOCK_LIMIT : bsz_reg);
        w = (wid_reg == '0) ? CFG_W'(1) : ((wid_reg > W_LIMIT) ? W_LIMIT : wid_reg);
        h = (hgt_reg == '0) ? CFG_W'(1) : ((hgt_reg > H_LIMIT) ? H_LIMIT : hgt_reg);
        bm1 = b - CFG_W'(1);
    end

    ocbf_extent u_extent (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .divisor (b),
        .width   (w),
        .height  (h),
        .ext     (ext)
    );

    assign s_tready = !ext.busy && !hold;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        // pull the position back inside the current bounds
        c0   = (col_reg >= w) ? '0 : col_reg;
        cib0 = (col_reg >= w) ? '0 : cib_reg;
        idx0 = (col_reg >= w) ? '0 : idx_reg;
        r0   = (row_reg >= h) ? '0 : row_reg;
        rib0 = (row_reg >= h) ? '0 : rib_reg;
        cib1 = ({1'b0, cib0} >= b) ? '0 : cib0;
        rib1 = ({1'b0, rib0} >= b) ? '0 : rib0;

        in_full = (c0 < ext.full_cols) && (r0 < ext.full_rows);

        push_op.idx      = idx0;
        push_op.first    = (rib1 == '0) && (cib1 == '0);
        push_op.last_pix = ({1'b0, rib1} == bm1) && ({1'b0, cib1} == bm1);
        push_op.below    = (s_tdata < thr_reg);
        push_op.crow     = r0[COORD_W-1:0] - bm1[COORD_W-1:0]
                           + {1'b0, bm1[COORD_W-1:1]};
        push_op.ccol     = c0[COORD_W-1:0] - bm1[COORD_W-1:0]
                           + {1'b0, bm1[COORD_W-1:1]};
        push_op.last_blk = (r0 == ext.full_rows - CFG_W'(1))
                           && (c0 == ext.full_cols - CFG_W'(1));
        push = accept && in_full;

        // advance the position
        cib_inc  = {1'b0, cib1} + CFG_W'(1);
        c_inc    = c0 + POS_W'(1);
        rib_inc  = {1'b0, rib1} + CFG_W'(1);
        r_inc    = r0 + POS_W'(1);
        cib_next = (cib_inc >= b) ? '0 : cib_inc[BLK_W-1:0];
        idx_next = (cib_inc >= b) ? idx0 + POS_W'(1) : idx0;
        col_next = c_inc;
        rib_next = rib1;
        row_next = r0;
        if (c_inc >= w) begin
            col_next = '0;
            cib_next = '0;
            idx_next = '0;
            rib_next = (rib_inc >= b) ? '0 : rib_inc[BLK_W-1:0];
            row_next = r_inc;
            if (r_inc >= h) begin
                row_next = '0;
                rib_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            cib_reg <= '0;
            rib_reg <= '0;
            idx_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
            cib_reg <= cib_next;
            rib_reg <= rib_next;
            idx_reg <= idx_next;
        end
    end

endmodule

// File: rtl/core/ocbf_queue.sv
// short fifo between front and back
// uses ocbf_pkg
module ocbf_queue import ocbf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  blk_op_t push_op,
    output logic    full,
    output logic    head_valid,
    output blk_op_t head_op,
    input  logic    pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    blk_op_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_op    = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + CNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - CNT_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// File: rtl/core/ocbf_back.sv
// back part: block flag read-modify-write, result register, clearing pass
// uses ocbf_pkg and ocbf_ram
module ocbf_back import ocbf_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  blk_op_t               head_op,
    output logic                  pop,
    output logic                  clr_busy,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    localparam int AW = $clog2(DEPTH);

    logic          clr_reg;
    logic [AW-1:0] clr_addr_reg;

    logic          b_valid_reg;
    blk_op_t       b_op_reg;
    logic          fwd_hit_reg;
    logic          fwd_val_reg;

    logic               o_valid_reg;
    logic [COORD_W-1:0] o_crow_reg, o_ccol_reg;
    logic               o_acc_reg, o_last_reg;

    logic          ram_q;
    logic          cur_flag, new_flag;
    logic          o_free, b_leave, b_load;
    logic          ram_we, ram_wdata;
    logic [AW-1:0] ram_waddr;

    assign clr_busy = clr_reg;

    // flag as it stands before this pixel; forward a write made as this op was loaded
    assign cur_flag = fwd_hit_reg ? fwd_val_reg : ram_q;
    assign new_flag = b_op_reg.first ? b_op_reg.below : (cur_flag || b_op_reg.below);

    assign o_free  = !o_valid_reg || m_tready;
    assign b_leave = b_valid_reg && (!b_op_reg.last_pix || o_free);
    assign b_load  = head_valid && !clr_reg && (!b_valid_reg || b_leave);
    assign pop     = b_load;

    assign ram_we    = clr_reg || b_leave;
    assign ram_waddr = clr_reg ? clr_addr_reg : b_op_reg.idx[AW-1:0];
    assign ram_wdata = clr_reg ? 1'b0 : new_flag;

    ocbf_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_flags (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (b_load),
        .raddr (head_op.idx[AW-1:0]),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            b_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else begin
            if (clr_reg) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
            if (b_load) begin
                b_valid_reg <= 1'b1;
            end else if (b_leave) begin
                b_valid_reg <= 1'b0;
            end
            if (b_leave && b_op_reg.last_pix) begin
                o_valid_reg <= 1'b1;
            end else if (m_tready) begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_load) begin
            b_op_reg    <= head_op;
            fwd_hit_reg <= b_leave && (b_op_reg.idx == head_op.idx);
            fwd_val_reg <= new_flag;
        end
        if (b_leave && b_op_reg.last_pix) begin
            o_crow_reg <= b_op_reg.crow;
            o_ccol_reg <= b_op_reg.ccol;
            o_acc_reg  <= !new_flag;
            o_last_reg <= b_op_reg.last_blk;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, o_acc_reg, o_ccol_reg, o_crow_reg};
    assign m_tlast  = o_last_reg;

endmodule

// File: rtl/core/ocbf_checker.sv
// port-level checks of the occupancy block checker, bound to the top level
// uses ocbf_pkg and occupancy_block_free_check_macros.svh
`include "occupancy_block_free_check_macros.svh"

module ocbf_checker import ocbf_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    `OCBF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `OCBF_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
    // the flag memory is being cleared right after reset
    `OCBF_ASSERT_NEXT_ALWAYS(a_clear_after_reset, aclk, !aresetn, !s_tready, "pixel taken during clearing pass")
    // geometry change reruns the extent unit before any pixel is taken
    `OCBF_ASSERT_NEXT(a_geom_hold, aclk, aresetn, cfg_valid && cfg_ready && (cfg_index == REG_BLOCK_SIZE || cfg_index == REG_MAP_WIDTH || cfg_index == REG_MAP_HEIGHT), !s_tready, "pixel taken before extent update")

endmodule

bind occupancy_block_free_check ocbf_checker u_ocbf_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);
